@@ sv/speck_block_cipher_assert.svh @@
// Assertion macros for the cipher block.
`ifndef SPECK_BLOCK_CIPHER_ASSERT_SVH
`define SPECK_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTH
// Check a condition at every rising clock edge outside reset.
`define SPK_ASSERT_HOLD(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check a consequence in the same cycle.
`define SPK_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check a consequence in the following cycle.
`define SPK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPK_ASSERT_HOLD(label, clk, rst, expr, msg)
`define SPK_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SPK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ sv/spk_pkg.sv @@
`timescale 1ns / 1ps
package spk_pkg;

  // Port width of every key, block and result word.
  localparam int FIELD_BITS = 64;

  // Cipher geometry.
  localparam int WORD_BITS   = 64;
  localparam int ROUND_COUNT = 32;
  localparam int ROT_A       = 8;
  localparam int ROT_B       = 3;

  // Round-key store addressing.
  localparam int RK_ADDR_BITS = $clog2(ROUND_COUNT);

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_HIGH = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LOW  = CFG_INDEX_BITS'(1);

  typedef logic [WORD_BITS-1:0]    word_t;
  typedef logic [RK_ADDR_BITS-1:0] rk_addr_t;

endpackage

@@ sv/speck_block_cipher.sv @@
`timescale 1ns / 1ps
// Speck128/128 block cipher engine. Write the two key words through the write port
// (index 0 key_high, index 1 key_low) while the engine is idle; any key write marks the
// round keys stale. Pulse start while busy is low to issue a transaction: mode 0
// encrypts, mode 1 decrypts the block {block_high, block_low}. The result appears on
// result_high/result_low for exactly one cycle with done high; the receiver cannot stall
// it, so capture it in that cycle. One shared round unit does one round per cycle and
// the round keys live in a 32-entry synchronous RAM, so a transaction first fetches
// the first round key (ST_PREP) and then runs the rounds (ST_RUN). The first
// transaction after reset or after a key write first runs the key schedule through
// the same round unit, writing one round key per cycle. A new transaction may be
// issued in the cycle done is high.
module speck_block_cipher (
  input  logic                                   clk,
  input  logic                                   rst,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   mode,
  input  logic [spk_pkg::FIELD_BITS-1:0]         block_high,
  input  logic [spk_pkg::FIELD_BITS-1:0]         block_low,
  // result channel
  output logic                                   done,
  output logic [spk_pkg::FIELD_BITS-1:0]         result_high,
  output logic [spk_pkg::FIELD_BITS-1:0]         result_low,
  // key write port
  input  logic                                   wr_en,
  input  logic [spk_pkg::CFG_INDEX_BITS-1:0]     wr_index,
  input  logic [spk_pkg::FIELD_BITS-1:0]         wr_data
);

  `include "speck_block_cipher_assert.svh"

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPAND = 2'd1;
  localparam logic [1:0] ST_PREP   = 2'd2;
  localparam logic [1:0] ST_RUN    = 2'd3;

  logic [1:0]        state;
  logic              keys_current;
  spk_pkg::word_t    key_left;
  spk_pkg::word_t    key_right;
  spk_pkg::rk_addr_t cnt;

  // Payload of the transaction in flight and the key schedule words.
  logic              dec;
  spk_pkg::word_t    x;
  spk_pkg::word_t    y;
  spk_pkg::word_t    kl;
  spk_pkg::word_t    kr;

  // Shared round unit.
  spk_pkg::word_t    rnd_x;
  spk_pkg::word_t    rnd_y;
  spk_pkg::word_t    rnd_k;
  logic              rnd_dec;
  spk_pkg::word_t    rnd_x_next;
  spk_pkg::word_t    rnd_y_next;

  // Round-key RAM.
  logic              rk_we;
  spk_pkg::rk_addr_t rk_raddr;
  spk_pkg::word_t    rk_rdata;

  logic              last;
  logic              accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign last   = (cnt == spk_pkg::RK_ADDR_BITS'(spk_pkg::ROUND_COUNT - 1));

  always_comb begin
    // Expansion runs forward rounds on the key words with the round index as key.
    if (state == ST_EXPAND) begin
      rnd_x   = kl;
      rnd_y   = kr;
      rnd_k   = spk_pkg::WORD_BITS'(cnt);
      rnd_dec = 1'b0;
    end else begin
      rnd_x   = x;
      rnd_y   = y;
      rnd_k   = rk_rdata;
      rnd_dec = dec;
    end

    rk_we = (state == ST_EXPAND);

    // Fetch the round key in the cycle before the round that uses it.
    case (state)
      ST_PREP: begin
        rk_raddr = dec ? spk_pkg::RK_ADDR_BITS'(spk_pkg::ROUND_COUNT - 1) : '0;
      end
      ST_RUN: begin
        if (last) begin
          rk_raddr = '0;
        end else if (dec) begin
          rk_raddr = spk_pkg::RK_ADDR_BITS'(spk_pkg::ROUND_COUNT - 2) - cnt;
        end else begin
          rk_raddr = cnt + spk_pkg::RK_ADDR_BITS'(1);
        end
      end
      default: begin
        rk_raddr = '0;
      end
    endcase
  end

  spk_round u_round (
    .x      (rnd_x),
    .y      (rnd_y),
    .k      (rnd_k),
    .dec    (rnd_dec),
    .x_next (rnd_x_next),
    .y_next (rnd_y_next)
  );

  spk_ram #(
    .WIDTH (spk_pkg::WORD_BITS),
    .DEPTH (spk_pkg::ROUND_COUNT)
  ) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (cnt),
    .wdata (kr),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  // Control, key registers and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      keys_current <= 1'b0;
      key_left     <= '0;
      key_right    <= '0;
      cnt          <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= keys_current ? ST_PREP : ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          if (last) begin
            cnt          <= '0;
            keys_current <= 1'b1;
            state        <= ST_PREP;
          end else begin
            cnt <= cnt + spk_pkg::RK_ADDR_BITS'(1);
          end
        end
        ST_PREP: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (last) begin
            cnt   <= '0;
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + spk_pkg::RK_ADDR_BITS'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Any key write drops the expanded round keys.
      if (wr_en) begin
        case (wr_index)
          spk_pkg::REG_KEY_HIGH: begin
            key_left     <= wr_data[spk_pkg::WORD_BITS-1:0];
            keys_current <= 1'b0;
          end
          spk_pkg::REG_KEY_LOW: begin
            key_right    <= wr_data[spk_pkg::WORD_BITS-1:0];
            keys_current <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          dec <= mode;
          x   <= block_high[spk_pkg::WORD_BITS-1:0];
          y   <= block_low[spk_pkg::WORD_BITS-1:0];
          kl  <= key_left;
          kr  <= key_right;
        end
      end
      ST_EXPAND: begin
        kl <= rnd_x_next;
        kr <= rnd_y_next;
      end
      ST_RUN: begin
        x <= rnd_x_next;
        y <= rnd_y_next;
        if (last) begin
          result_high <= spk_pkg::FIELD_BITS'(rnd_x_next);
          result_low  <= spk_pkg::FIELD_BITS'(rnd_y_next);
        end
      end
      default: begin
      end
    endcase
  end

  // The last round always produces exactly one strobe, in the idle cycle that follows.
  `SPK_ASSERT_NEXT(a_last_done, clk, rst, (state == ST_RUN) && last, done && !busy, "last round did not raise done")
  `SPK_ASSERT_IMPLY(a_done_src, clk, rst, done, $past(state) == ST_RUN, "done without a finished round sequence")
  // Stale keys can only come from a key write.
  `SPK_ASSERT_IMPLY(a_keys_drop, clk, rst, $fell(keys_current), $past(wr_en), "round keys dropped without a key write")
  // An accepted transaction always leaves idle.
  `SPK_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted transaction did not start")

endmodule

@@ sv/spk_ram.sv @@
`timescale 1ns / 1ps
module spk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/spk_round.sv @@
`timescale 1ns / 1ps
module spk_round (
  input  spk_pkg::word_t x,
  input  spk_pkg::word_t y,
  input  spk_pkg::word_t k,
  input  logic           dec,
  output spk_pkg::word_t x_next,
  output spk_pkg::word_t y_next
);

  spk_pkg::word_t fx;
  spk_pkg::word_t fy;
  spk_pkg::word_t iy;
  spk_pkg::word_t ix;
  spk_pkg::word_t x_ror;
  spk_pkg::word_t y_rol;
  spk_pkg::word_t xy;
  spk_pkg::word_t diff;

  always_comb begin
    // Forward: x = (x ror A) + y ^ k, y = (y rol B) ^ x.
    x_ror = (x >> spk_pkg::ROT_A) | (x << (spk_pkg::WORD_BITS - spk_pkg::ROT_A));
    fx    = (x_ror + y) ^ k;
    y_rol = (y << spk_pkg::ROT_B) | (y >> (spk_pkg::WORD_BITS - spk_pkg::ROT_B));
    fy    = y_rol ^ fx;
    // Inverse: undo the y step first, then the x step.
    xy    = y ^ x;
    iy    = (xy >> spk_pkg::ROT_B) | (xy << (spk_pkg::WORD_BITS - spk_pkg::ROT_B));
    diff  = (x ^ k) - iy;
    ix    = (diff << spk_pkg::ROT_A) | (diff >> (spk_pkg::WORD_BITS - spk_pkg::ROT_A));
    x_next = dec ? ix : fx;
    y_next = dec ? iy : fy;
  end

endmodule

@@ verif/speck_block_cipher_tb.sv @@
`timescale 1ns / 1ps
module speck_block_cipher_tb;

  // Mode codes on the command channel.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Indexes the block does not decode; a write there must leave the key alone.
  localparam logic [spk_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = spk_pkg::CFG_INDEX_BITS'(2);
  localparam logic [spk_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = spk_pkg::CFG_INDEX_BITS'(3);

  // Worst case is about 1500 transactions, each running the key schedule and
  // followed by the longest gap; allow several times that.
  localparam int CYCLE_LIMIT  = 900000;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_REPORTED = 10;
  localparam int MAX_GAP      = 70;

  typedef struct packed {
    spk_pkg::word_t hi;
    spk_pkg::word_t lo;
  } block_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = MODE_ENCRYPT;
  logic [spk_pkg::FIELD_BITS-1:0] block_high = '0;
  logic [spk_pkg::FIELD_BITS-1:0] block_low = '0;
  logic done;
  logic [spk_pkg::FIELD_BITS-1:0] result_high;
  logic [spk_pkg::FIELD_BITS-1:0] result_low;
  logic wr_en = 1'b0;
  logic [spk_pkg::CFG_INDEX_BITS-1:0] wr_index = spk_pkg::REG_KEY_HIGH;
  logic [spk_pkg::FIELD_BITS-1:0] wr_data = '0;

  speck_block_cipher uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .block_high(block_high),
    .block_low(block_low),
    .done(done),
    .result_high(result_high),
    .result_low(result_low),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher predictor: shadow key registers, shadow round-key schedule, and the
  // stale flag that any key write raises.
  // ---------------------------------------------------------------------------
  spk_pkg::word_t shadow_key_high = '0;
  spk_pkg::word_t shadow_key_low  = '0;
  spk_pkg::word_t round_keys [spk_pkg::ROUND_COUNT];
  logic           round_keys_fresh = 1'b0;

  // Ciphertexts/plaintexts still owed by the block, oldest first.
  block_t pending_blocks [$];

  // Last transaction, so a later one can run it backwards.
  logic   last_op = MODE_ENCRYPT;
  block_t last_out;
  logic   have_last = 1'b0;

  int error_count    = 0;
  int results_seen   = 0;
  int encrypts_sent  = 0;
  int decrypts_sent  = 0;
  int schedules_run  = 0;
  int key_writes     = 0;
  int cycle_count    = 0;

  function automatic spk_pkg::word_t spk_ror(input spk_pkg::word_t v, input int r);
    return (v >> r) | (v << (spk_pkg::WORD_BITS - r));
  endfunction

  function automatic spk_pkg::word_t spk_rol(input spk_pkg::word_t v, input int r);
    return (v << r) | (v >> (spk_pkg::WORD_BITS - r));
  endfunction

  function automatic void speck_round_fwd(inout spk_pkg::word_t x, inout spk_pkg::word_t y,
                                          input spk_pkg::word_t k);
    x = (spk_ror(x, spk_pkg::ROT_A) + y) ^ k;
    y = spk_rol(y, spk_pkg::ROT_B) ^ x;
  endfunction

  function automatic void speck_round_inv(inout spk_pkg::word_t x, inout spk_pkg::word_t y,
                                          input spk_pkg::word_t k);
    y = spk_ror(y ^ x, spk_pkg::ROT_B);
    x = spk_rol((x ^ k) - y, spk_pkg::ROT_A);
  endfunction

  // Key schedule: the round function again, with the round number as key.
  function automatic void expand_round_keys();
    spk_pkg::word_t l;
    spk_pkg::word_t r;
    l = shadow_key_high;
    r = shadow_key_low;
    for (int i = 0; i < spk_pkg::ROUND_COUNT; i++) begin
      round_keys[i] = r;
      speck_round_fwd(l, r, spk_pkg::word_t'(i));
    end
    round_keys_fresh = 1'b1;
    schedules_run++;
  endfunction

  function automatic block_t cipher_block(input logic op, input spk_pkg::word_t hi,
                                          input spk_pkg::word_t lo);
    spk_pkg::word_t x;
    spk_pkg::word_t y;
    x = hi;
    y = lo;
    if (!round_keys_fresh) expand_round_keys();
    if (op == MODE_ENCRYPT) begin
      for (int i = 0; i < spk_pkg::ROUND_COUNT; i++) speck_round_fwd(x, y, round_keys[i]);
    end else begin
      for (int i = spk_pkg::ROUND_COUNT - 1; i >= 0; i--) speck_round_inv(x, y, round_keys[i]);
    end
    return '{hi: x, lo: y};
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. done lasts one cycle and cannot be stalled, so sample it
  // at every edge and match against the oldest pending block.
  // ---------------------------------------------------------------------------
  function automatic void flag_error(input string what, input spk_pkg::word_t want,
                                     input spk_pkg::word_t got);
    error_count++;
    if (error_count <= MAX_REPORTED)
      $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    block_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_blocks.size() == 0) begin
        flag_error("result with no transaction pending (high word)", '0, result_high);
      end else begin
        want = pending_blocks.pop_front();
        if (result_high !== want.hi) flag_error("result_high mismatch", want.hi, result_high);
        if (result_low !== want.lo) flag_error("result_low mismatch", want.lo, result_low);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_blocks.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left just after a rising edge.
  // ---------------------------------------------------------------------------

  // Issue one transaction and hold it until the block takes it. start is left
  // high so back-to-back transactions need no extra assignment.
  task automatic send_block(input logic op, input spk_pkg::word_t hi, input spk_pkg::word_t lo);
    block_t outcome;
    start      <= 1'b1;
    mode       <= op;
    block_high <= hi;
    block_low  <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    outcome = cipher_block(op, hi, lo);
    pending_blocks.push_back(outcome);
    if (op == MODE_ENCRYPT) encrypts_sent++;
    else decrypts_sent++;
    last_op   = op;
    last_out  = outcome;
    have_last = 1'b1;
  endtask

  // Drop start and let the sender idle.
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start and hold off until every owed result is back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  // Key register write; only called with the block idle. Return only after wr_en
  // has been low across a clock edge, so it never gets two assignments in one step.
  task automatic write_key_reg(input logic [spk_pkg::CFG_INDEX_BITS-1:0] idx,
                               input spk_pkg::word_t value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    key_writes++;
    case (idx)
      spk_pkg::REG_KEY_HIGH: begin
        shadow_key_high  = value;
        round_keys_fresh = 1'b0;
      end
      spk_pkg::REG_KEY_LOW: begin
        shadow_key_low   = value;
        round_keys_fresh = 1'b0;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Word generator biased toward the corners: zero, all ones, one-hot,
  // an alternating pattern, otherwise fully random.
  function automatic spk_pkg::word_t pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return spk_pkg::word_t'(1) << $urandom_range(spk_pkg::WORD_BITS - 1);
      3: return {spk_pkg::WORD_BITS/2{2'b10}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_random_key();
    case ($urandom_range(4))
      0: write_key_reg(spk_pkg::REG_KEY_HIGH, pick_word());
      1: write_key_reg(spk_pkg::REG_KEY_LOW, pick_word());
      2, 3: begin
        write_key_reg(spk_pkg::REG_KEY_HIGH, pick_word());
        write_key_reg(spk_pkg::REG_KEY_LOW, pick_word());
      end
      default: write_key_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, pick_word());
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset key is zero; the very first transaction also runs the key schedule.
  task automatic test_reset_key();
    send_block(MODE_ENCRYPT, '0, '0);
    send_block(MODE_DECRYPT, '0, '0);
    send_block(MODE_ENCRYPT, '1, '1);
    send_block(MODE_DECRYPT, '1, '1);
    drain_results();
  endtask

  // Published Speck128/128 vector, both directions.
  task automatic test_known_vector();
    write_key_reg(spk_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    write_key_reg(spk_pkg::REG_KEY_LOW, 64'h0706050403020100);
    send_block(MODE_ENCRYPT, 64'h6c61766975716520, 64'h7469206564616d20);
    send_block(MODE_DECRYPT, 64'ha65d985179783265, 64'h7860fedf5c570d18);
    drain_results();
  endtask

  // All-ones key against corner blocks.
  task automatic test_key_extremes();
    write_key_reg(spk_pkg::REG_KEY_HIGH, '1);
    write_key_reg(spk_pkg::REG_KEY_LOW, '1);
    send_block(MODE_ENCRYPT, '0, '0);
    send_block(MODE_ENCRYPT, '1, '1);
    send_block(MODE_DECRYPT, {spk_pkg::WORD_BITS/2{2'b10}}, {spk_pkg::WORD_BITS/2{2'b01}});
    send_block(MODE_ENCRYPT, spk_pkg::word_t'(1) << (spk_pkg::WORD_BITS - 1),
               spk_pkg::word_t'(1));
    send_block(MODE_DECRYPT, '1, '0);
    send_block(MODE_DECRYPT, spk_pkg::word_t'(1),
               spk_pkg::word_t'(1) << (spk_pkg::WORD_BITS - 1));
    drain_results();
  endtask

  // Rewriting the same key forces a fresh schedule; writes to the undecoded
  // indexes must not disturb the key.
  task automatic test_key_rewrite();
    write_key_reg(spk_pkg::REG_KEY_LOW, shadow_key_low);
    send_block(MODE_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(MODE_DECRYPT, last_out.hi, last_out.lo);
    drain_results();
    write_key_reg(REG_SPARE_2, '0);
    write_key_reg(REG_SPARE_3, '1);
    send_block(MODE_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(MODE_DECRYPT, '0, '1);
    drain_results();
  endtask

  // Random traffic with occasional key changes, full drains, and round trips
  // that feed a result back in the opposite direction.
  task automatic test_random_traffic(input int idle_pct, input int n_items);
    logic           op;
    spk_pkg::word_t hi;
    spk_pkg::word_t lo;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 3) begin
        drain_results();
        load_random_key();
      end else if ($urandom_range(99) < 2) begin
        drain_results();
      end
      if (have_last && $urandom_range(99) < 20) begin
        op = (last_op == MODE_ENCRYPT) ? MODE_DECRYPT : MODE_ENCRYPT;
        hi = last_out.hi;
        lo = last_out.lo;
      end else begin
        op = $urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT;
        hi = pick_word();
        lo = pick_word();
      end
      send_block(op, hi, lo);
      // Gaps up to MAX_GAP land on every phase of the work.
      if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, MAX_GAP));
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_key();
    test_known_vector();
    test_key_extremes();
    test_key_rewrite();

    // The receiver cannot stall results, so only the sender idles.
    test_random_traffic(0, 480);
    test_random_traffic(48, 480);
    write_key_reg(spk_pkg::REG_KEY_HIGH, '0);
    write_key_reg(spk_pkg::REG_KEY_LOW, '1);
    test_random_traffic(31, 475);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_blocks.size() != 0) begin
      error_count += pending_blocks.size();
      $display("%0d results never arrived", pending_blocks.size());
    end

    $display("Checked %0d results from %0d encrypt and %0d decrypt transactions",
             results_seen, encrypts_sent, decrypts_sent);
    $display("Key schedule rebuilt %0d times over %0d key writes; %0d mismatches",
             schedules_run, key_writes, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/spk_pkg.sv
sv/spk_ram.sv
sv/spk_round.sv
sv/speck_block_cipher.sv
verif/speck_block_cipher_tb.sv
